FILE: rtl/pmd_pkg.sv
package pmd_pkg;

    // Symbol and code sizes.
    localparam int MaxSymbols  = 15;
    localparam int LenW        = $clog2(MaxSymbols + 1);
    localparam int PatW        = MaxSymbols;
    localparam int SymW        = 2;
    localparam int SymsPerByte = 4;
    localparam int ByteW       = SymW * SymsPerByte;
    localparam int IdxW        = $clog2(SymsPerByte);
    localparam int CharW       = 7;

    // Key widths of the fixed code table.
    localparam int TableLenW = 4;
    localparam int TablePatW = 15;

    // Byte queue between the front and the back.
    localparam int QueueDepth = 2;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [CharW-1:0] CharSpace = 7'h20;

    typedef enum logic [SymW-1:0] {
        SYM_END   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_DOT   = 2'd2,
        SYM_SPACE = 2'd3
    } t_sym;

    // Element 0 holds the first symbol of the byte.
    typedef logic [SymsPerByte-1:0][SymW-1:0] t_group;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_queue_out;

    typedef struct packed {
        logic             hit;
        logic [CharW-1:0] code;
    } t_lookup;

    // Direct match of a pending code against the fixed Morse table.
    // Patterns hold the oldest symbol in the highest used bit, 1 for a dash.
    function automatic t_lookup morse_lookup(input logic [LenW-1:0] len,
                                             input logic [PatW-1:0] pat);
        t_lookup res;
        logic [TableLenW+TablePatW-1:0] key;
        key      = {TableLenW'(len), TablePatW'(pat)};
        res.hit  = 1'b1;
        res.code = '0;
        case (key)
            {4'd2, 15'b01}:      res.code = 7'h41; // A
            {4'd4, 15'b1000}:    res.code = 7'h42; // B
            {4'd4, 15'b1010}:    res.code = 7'h43; // C
            {4'd3, 15'b100}:     res.code = 7'h44; // D
            {4'd1, 15'b0}:       res.code = 7'h45; // E
            {4'd4, 15'b0010}:    res.code = 7'h46; // F
            {4'd3, 15'b110}:     res.code = 7'h47; // G
            {4'd4, 15'b0000}:    res.code = 7'h48; // H
            {4'd2, 15'b00}:      res.code = 7'h49; // I
            {4'd4, 15'b0111}:    res.code = 7'h4A; // J
            {4'd3, 15'b101}:     res.code = 7'h4B; // K
            {4'd4, 15'b0100}:    res.code = 7'h4C; // L
            {4'd2, 15'b11}:      res.code = 7'h4D; // M
            {4'd2, 15'b10}:      res.code = 7'h4E; // N
            {4'd3, 15'b111}:     res.code = 7'h4F; // O
            {4'd4, 15'b0110}:    res.code = 7'h50; // P
            {4'd4, 15'b1101}:    res.code = 7'h51; // Q
            {4'd3, 15'b010}:     res.code = 7'h52; // R
            {4'd3, 15'b000}:     res.code = 7'h53; // S
            {4'd1, 15'b1}:       res.code = 7'h54; // T
            {4'd3, 15'b001}:     res.code = 7'h55; // U
            {4'd4, 15'b0001}:    res.code = 7'h56; // V
            {4'd3, 15'b011}:     res.code = 7'h57; // W
            {4'd4, 15'b1001}:    res.code = 7'h58; // X
            {4'd4, 15'b1011}:    res.code = 7'h59; // Y
            {4'd4, 15'b1100}:    res.code = 7'h5A; // Z
            {4'd5, 15'b11111}:   res.code = 7'h30; // 0
            {4'd5, 15'b01111}:   res.code = 7'h31; // 1
            {4'd5, 15'b00111}:   res.code = 7'h32; // 2
            {4'd5, 15'b00011}:   res.code = 7'h33; // 3
            {4'd5, 15'b00001}:   res.code = 7'h34; // 4
            {4'd5, 15'b00000}:   res.code = 7'h35; // 5
            {4'd5, 15'b10000}:   res.code = 7'h36; // 6
            {4'd5, 15'b11000}:   res.code = 7'h37; // 7
            {4'd5, 15'b11100}:   res.code = 7'h38; // 8
            {4'd5, 15'b11110}:   res.code = 7'h39; // 9
            {4'd5, 15'b01000}:   res.code = 7'h26; // ampersand
            {4'd6, 15'b011110}:  res.code = 7'h27; // apostrophe
            {4'd6, 15'b011010}:  res.code = 7'h40; // at sign
            {4'd6, 15'b101101}:  res.code = 7'h29; // right parenthesis
            {4'd5, 15'b10110}:   res.code = 7'h28; // left parenthesis
            {4'd6, 15'b111000}:  res.code = 7'h3A; // colon
            {4'd6, 15'b110011}:  res.code = 7'h2C; // comma
            {4'd5, 15'b10001}:   res.code = 7'h3D; // equals
            {4'd6, 15'b101011}:  res.code = 7'h21; // exclamation
            {4'd6, 15'b010101}:  res.code = 7'h2E; // period
            {4'd6, 15'b100001}:  res.code = 7'h2D; // hyphen
            {4'd15, 15'b111111001011111}: res.code = 7'h25; // percent
            {4'd5, 15'b01010}:   res.code = 7'h2B; // plus
            {4'd6, 15'b010010}:  res.code = 7'h22; // double quote
            {4'd6, 15'b001100}:  res.code = 7'h3F; // question mark
            {4'd5, 15'b10010}:   res.code = 7'h2F; // slash
            {4'd8, 15'b00000000}: res.code = 7'h5C; // backslash
            {4'd4, 15'b0101}:    res.code = 7'h0A; // newline
            default: begin
                res.hit  = 1'b0;
                res.code = '0;
            end
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/pmd_if.sv
// Input channel: one packed byte of four symbols per transfer.
interface pmd_in_if import pmd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] packed_symbols;

    modport source (output valid, output packed_symbols, input ready);
    modport sink   (input valid, input packed_symbols, output ready);
endinterface

// Output channel: one decoded character per transfer.
interface pmd_out_if import pmd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CharW-1:0] character;
    logic             last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/pmd_front.sv
module pmd_front import pmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmd_in_if.sink     i_in,
    input  logic       i_pop,
    output t_queue_out o_q
);

    t_group             split;
    logic               push;
    t_group             r_q [QueueDepth];
    logic [QPtrW-1:0]   r_wptr;
    logic [QPtrW-1:0]   r_rptr;
    logic [QCntW-1:0]   r_count;
    logic [QPtrW-1:0]   n_wptr;
    logic [QPtrW-1:0]   n_rptr;
    logic [QCntW-1:0]   n_count;

    // Split the byte into symbols, first symbol in element 0.
    always_comb begin
        for (int k = 0; k < SymsPerByte; k++) begin
            split[k] = i_in.packed_symbols[ByteW-1-SymW*k -: SymW];
        end
    end

    // The queue takes a byte whenever it has a free entry.
    assign i_in.ready = (r_count != QCntW'(QueueDepth));
    assign push       = i_in.valid && i_in.ready;

    // Pointer and fill count updates.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPtrW'(QueueDepth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPtrW'(QueueDepth - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= split;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.group = r_q[r_rptr];

endmodule

FILE: rtl/pmd_back.sv
module pmd_back import pmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_q,
    output logic       o_pop,
    pmd_out_if.source  o_out
);

    // Symbol sequencer.
    logic              r_busy;
    logic [IdxW-1:0]   r_idx;
    t_group            r_group;
    logic              n_busy;
    logic [IdxW-1:0]   n_idx;
    t_group            n_group;

    // Pending code.
    logic [LenW-1:0]   r_len;
    logic [PatW-1:0]   r_pat;
    logic              r_ovf;
    logic [LenW-1:0]   n_len;
    logic [PatW-1:0]   n_pat;
    logic              n_ovf;

    // Held result, waiting to learn whether it is the last of its byte.
    logic              r_hold_v;
    logic              r_hold_final;
    logic [CharW-1:0]  r_hold_char;
    logic              n_hold_v;
    logic              n_hold_final;
    logic [CharW-1:0]  n_hold_char;

    // Output register.
    logic              r_out_v;
    logic [CharW-1:0]  r_out_char;
    logic              r_out_last;
    logic              n_out_v;
    logic [CharW-1:0]  n_out_char;
    logic              n_out_last;

    t_sym              sym;
    logic              eob;
    t_lookup           found;
    logic              emit;
    logic [CharW-1:0]  emit_char;
    logic              out_free;
    logic              flush;
    logic              hold_cur;
    logic              ev_send;
    logic              ev_ok;

    // Current symbol and its table match.
    assign sym   = t_sym'(r_group[r_idx]);
    assign eob   = (r_idx == IdxW'(SymsPerByte - 1));
    assign found = morse_lookup(r_len, r_pat);

    always_comb begin
        emit      = 1'b0;
        emit_char = found.code;
        case (sym)
            SYM_SPACE: begin
                emit      = 1'b1;
                emit_char = CharSpace;
            end
            SYM_END: begin
                emit = !r_ovf && (r_len != '0) && found.hit;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // A final held result drains on its own; a symbol step stalls only when
    // it must move the held result and the output register is occupied.
    assign out_free = !r_out_v || o_out.ready;
    assign flush    = r_hold_v && r_hold_final && out_free;
    assign hold_cur = r_hold_v && !r_hold_final;
    assign ev_send  = hold_cur && (emit || eob);
    assign ev_ok    = r_busy && !(ev_send && !out_free)
                      && !(r_hold_v && r_hold_final && !flush && emit);
    assign o_pop    = i_q.valid && (!r_busy || (ev_ok && eob));

    // Next state of the sequencer, pending code, hold and output.
    always_comb begin
        n_busy       = r_busy;
        n_idx        = r_idx;
        n_group      = r_group;
        n_len        = r_len;
        n_pat        = r_pat;
        n_ovf        = r_ovf;
        n_hold_v     = r_hold_v;
        n_hold_final = r_hold_final;
        n_hold_char  = r_hold_char;
        n_out_v      = r_out_v && !o_out.ready;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;

        // Byte sequencing.
        if (ev_ok) begin
            n_idx = r_idx + 1'b1;
            if (eob) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy  = 1'b1;
            n_idx   = '0;
            n_group = i_q.group;
        end

        // Pending code update.
        if (ev_ok) begin
            case (sym)
                SYM_DASH, SYM_DOT: begin
                    if (r_len >= LenW'(MaxSymbols)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pat = {r_pat[PatW-2:0], (sym == SYM_DASH)};
                        n_len = r_len + 1'b1;
                    end
                end
                SYM_END: begin
                    n_len = '0;
                    n_pat = '0;
                    n_ovf = 1'b0;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end

        // Output register load.
        if (flush) begin
            n_out_v    = 1'b1;
            n_out_char = r_hold_char;
            n_out_last = 1'b1;
        end else if (ev_ok && ev_send) begin
            n_out_v    = 1'b1;
            n_out_char = r_hold_char;
            n_out_last = eob && !emit;
        end

        // Hold register update.
        if (ev_ok && emit) begin
            n_hold_v     = 1'b1;
            n_hold_final = eob;
            n_hold_char  = emit_char;
        end else if ((ev_ok && ev_send) || flush) begin
            n_hold_v     = 1'b0;
            n_hold_final = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_len        <= '0;
            r_pat        <= '0;
            r_ovf        <= 1'b0;
            r_hold_v     <= 1'b0;
            r_hold_final <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_idx        <= n_idx;
            r_len        <= n_len;
            r_pat        <= n_pat;
            r_ovf        <= n_ovf;
            r_hold_v     <= n_hold_v;
            r_hold_final <= n_hold_final;
            r_out_v      <= n_out_v;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_group     <= n_group;
        r_hold_char <= n_hold_char;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid     = r_out_v;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

    // The pending code never grows past its limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LenW'(MaxSymbols))
        else $error("pending length beyond the symbol limit");

    // Overflow can only be flagged once the code is full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LenW'(MaxSymbols)))
        else $error("overflow flagged on a code that is not full");

    // A letter end always clears the pending code and the overflow flag.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_ok && (sym == SYM_END)) |=> ((r_len == '0) && !r_ovf))
        else $error("letter end did not clear the pending code");

    // After the last symbol of a byte no unresolved result is left behind.
    a_eob_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_ok && eob) |=> !(r_hold_v && !r_hold_final))
        else $error("held result not resolved at end of byte");

endmodule

FILE: rtl/packed_morse_decoder.sv
// Channel   Direction  Payload                       Transfer
// i_in      in         packed_symbols[7:0]           i_in.valid && i_in.ready
// o_out     out        character[6:0], last          o_out.valid && o_out.ready
//
// The back end steps one symbol per cycle unless output back-pressure holds a step.
// A two-entry byte queue takes input while the back end works on an earlier byte.
// A result is held until a later emitting symbol or the byte's last symbol is stepped,
// then reaches the output in the next cycle; a last-symbol result waits for free output.
// Output back-pressure stalls the symbol step only when a result must move.
// Reset is synchronous and active low; it empties the queue and clears the pending code.
module packed_morse_decoder import pmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmd_in_if.sink    i_in,
    pmd_out_if.source o_out
);

    t_queue_out q;
    logic       pop;

    // Input side: symbol split and byte queue.
    pmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_q     (q)
    );

    // Decode side: symbol sequencer, code match and result output.
    pmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
